// ===== hw/rtl/bgs_pkg.sv =====
package bgs_pkg;

	localparam int IDX_W = 13;

	typedef enum logic [2:0] {
		CFG_X_ORIGIN    = 3'd0,
		CFG_Y_TOP       = 3'd1,
		CFG_U_PER_X     = 3'd2,
		CFG_V_PER_Y     = 3'd3,
		CFG_COLS_IN_USE = 3'd4,
		CFG_ROWS_IN_USE = 3'd5,
		CFG_VERT_EXAG   = 3'd6
	} cfg_idx_t;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic [31:0] x_origin;
		logic [31:0] y_top;
		logic [31:0] u_per_x;
		logic [31:0] v_per_y;
		logic [9:0]  cols_in_use;
		logic [9:0]  rows_in_use;
		logic [31:0] vert_exag;
	} bgs_cfg_t;

	typedef struct packed {
		logic        is_wr;
		logic        wr_ok;
		logic [8:0]  col;
		logic [8:0]  row;
		logic [15:0] height;
		logic        degen;
		logic        dx_neg;
		logic [31:0] dx;
		logic        dy_neg;
		logic [31:0] dy;
	} bgs_item_t;

endpackage

// ===== hw/rtl/bgs_front.sv =====
module bgs_front import bgs_pkg::*; #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic              start,
	input  logic              full,
	input  bgs_cfg_t          cfg,
	input  logic              req_type,
	input  logic [8:0]        cell_col,
	input  logic [8:0]        cell_row,
	input  logic [15:0]       cell_height,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	output logic              busy,
	output logic              push,
	output bgs_item_t         item
);

	logic [32:0] dx;
	logic [32:0] dy;

	assign busy = full;
	assign push = start && !full;

	// differences in 33 bits so the sign survives the full range
	assign dx = {query_x[31], query_x} - {cfg.x_origin[31], cfg.x_origin};
	assign dy = {cfg.y_top[31], cfg.y_top} - {query_y[31], query_y};

	always_comb begin
		item.is_wr  = (req_type == REQ_WRITE);
		item.wr_ok  = (32'(cell_col) < 32'(MAX_COLS)) && (32'(cell_row) < 32'(MAX_ROWS));
		item.col    = cell_col;
		item.row    = cell_row;
		item.height = cell_height;
		item.degen  = (cfg.cols_in_use == '0) || (cfg.rows_in_use == '0) ||
			(cfg.u_per_x == '0) || (cfg.v_per_y == '0);
		item.dx_neg = dx[32];
		item.dx     = dx[31:0];
		item.dy_neg = dy[32];
		item.dy     = dy[31:0];
	end

endmodule

// ===== hw/rtl/bgs_queue.sv =====
module bgs_queue import bgs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bgs_item_t push_item,
	output logic      full,
	output logic      pop,
	output bgs_item_t pop_item
);

	bgs_item_t   ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign pop      = (cnt_q != 2'd0);
	assign pop_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== hw/rtl/bgs_back.sv =====
module bgs_back import bgs_pkg::*; #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bgs_cfg_t    cfg,
	input  logic        in_valid,
	input  bgs_item_t   in_item,
	output logic        result_valid,
	output logic [15:0] height_m,
	output logic [31:0] height_scaled
);

	localparam int CW  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (CW > 1) ? CW - 1 : 1;
	localparam int RAW = (RW > 1) ? RW - 1 : 1;
	localparam int BANK_DEPTH = 2 ** (CAW + RAW);

	// stage 1: products
	logic        v_s1;
	bgs_item_t   item_s1;
	logic [63:0] mx_s1;
	logic [63:0] my_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		mx_s1   <= 64'(in_item.dx) * 64'(cfg.u_per_x);
		my_s1   <= 64'(in_item.dy) * 64'(cfg.v_per_y);
	end

	// stage 1 logic: clamp indices, bank addresses
	logic [IDX_W-1:0] ncol;
	logic [IDX_W-1:0] nrow;
	logic [IDX_W-1:0] ncol_m1;
	logic [IDX_W-1:0] nrow_m1;
	logic [CW-1:0]    c0;
	logic [CW-1:0]    c1;
	logic [RW-1:0]    r0;
	logic [RW-1:0]    r1;
	logic [15:0]      tx;
	logic [15:0]      ty;

	always_comb begin
		ncol = ({3'b0, cfg.cols_in_use} > IDX_W'(MAX_COLS)) ? IDX_W'(MAX_COLS)
			: {3'b0, cfg.cols_in_use};
		nrow = ({3'b0, cfg.rows_in_use} > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS)
			: {3'b0, cfg.rows_in_use};
		ncol_m1 = ncol - IDX_W'(1);
		nrow_m1 = nrow - IDX_W'(1);

		if (item_s1.dx_neg) begin
			c0 = '0;
			c1 = '0;
			tx = '0;
		end else if (mx_s1[63:32] >= 32'(ncol_m1)) begin
			c0 = ncol_m1[CW-1:0];
			c1 = ncol_m1[CW-1:0];
			tx = '0;
		end else begin
			c0 = mx_s1[32 +: CW];
			c1 = mx_s1[32 +: CW] + CW'(1);
			tx = mx_s1[31:16];
		end

		if (item_s1.dy_neg) begin
			r0 = '0;
			r1 = '0;
			ty = '0;
		end else if (my_s1[63:32] >= 32'(nrow_m1)) begin
			r0 = nrow_m1[RW-1:0];
			r1 = nrow_m1[RW-1:0];
			ty = '0;
		end else begin
			r0 = my_s1[32 +: RW];
			r1 = my_s1[32 +: RW] + RW'(1);
			ty = my_s1[31:16];
		end
	end

	logic [IDX_W-1:0] wcol_ext;
	logic [IDX_W-1:0] wrow_ext;
	logic             wr_en;

	assign wcol_ext = IDX_W'(item_s1.col);
	assign wrow_ext = IDX_W'(item_s1.row);
	assign wr_en    = v_s1 && item_s1.is_wr && item_s1.wr_ok;

	// stage 2: banked store read, split by row and column parity
	logic [15:0] rd_s2 [4];
	logic        v_s2;
	logic        degen_s2;
	logic        c0p_s2, c1p_s2, r0p_s2, r1p_s2;
	logic [15:0] tx_s2, ty_s2;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [15:0]          mem [BANK_DEPTH];
		logic [CW-1:0]        csel;
		logic [RW-1:0]        rsel;
		logic [IDX_W-1:0]     cext;
		logic [IDX_W-1:0]     rext;
		logic [CAW+RAW-1:0]   raddr;
		logic [CAW+RAW-1:0]   waddr;

		assign csel  = (c0[0] == b[0]) ? c0 : c1;
		assign rsel  = (r0[0] == b[1]) ? r0 : r1;
		assign cext  = IDX_W'(csel);
		assign rext  = IDX_W'(rsel);
		assign raddr = {rext[RAW:1], cext[CAW:1]};
		assign waddr = {wrow_ext[RAW:1], wcol_ext[CAW:1]};

		always_ff @(posedge clk) begin
			if (wr_en && (item_s1.row[0] == b[1]) && (item_s1.col[0] == b[0]))
				mem[waddr] <= item_s1.height;
			rd_s2[b] <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1 && !item_s1.is_wr;
	end

	always_ff @(posedge clk) begin
		degen_s2 <= item_s1.degen;
		c0p_s2   <= c0[0];
		c1p_s2   <= c1[0];
		r0p_s2   <= r0[0];
		r1p_s2   <= r1[0];
		tx_s2    <= tx;
		ty_s2    <= ty;
	end

	// stage 2 logic: horizontal blend as h00*2^16 + (h10 - h00)*tx
	logic [15:0]        h00, h10, h01, h11;
	logic signed [16:0] dx0, dx1;
	logic signed [33:0] p0, p1;
	logic signed [33:0] h0_full, h1_full;

	always_comb begin
		h00 = rd_s2[{r0p_s2, c0p_s2}];
		h10 = rd_s2[{r0p_s2, c1p_s2}];
		h01 = rd_s2[{r1p_s2, c0p_s2}];
		h11 = rd_s2[{r1p_s2, c1p_s2}];
		dx0 = $signed({1'b0, h10}) - $signed({1'b0, h00});
		dx1 = $signed({1'b0, h11}) - $signed({1'b0, h01});
		p0  = 34'(dx0) * 34'($signed({1'b0, tx_s2}));
		p1  = 34'(dx1) * 34'($signed({1'b0, tx_s2}));
		h0_full = $signed({2'b0, h00, 16'b0}) + p0;
		h1_full = $signed({2'b0, h01, 16'b0}) + p1;
	end

	logic        v_s3;
	logic        degen_s3;
	logic [31:0] h0_s3, h1_s3;
	logic [15:0] ty_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		degen_s3 <= degen_s2;
		h0_s3    <= h0_full[31:0];
		h1_s3    <= h1_full[31:0];
		ty_s3    <= ty_s2;
	end

	// stage 3 logic: vertical blend
	logic signed [32:0] dv;
	logic signed [49:0] pv;
	logic signed [49:0] blend;

	always_comb begin
		dv    = $signed({1'b0, h1_s3}) - $signed({1'b0, h0_s3});
		pv    = 50'(dv) * 50'($signed({1'b0, ty_s3}));
		blend = $signed({2'b0, h0_s3, 16'b0}) + pv;
	end

	logic        v_s4;
	logic [15:0] hm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		hm_s4 <= degen_s3 ? 16'd0 : blend[47:32];
	end

	// output: scale by exaggeration, Q14.2 * Q4.28 >> 16 gives Q18.14
	logic [47:0] hs_full;
	logic        result_valid_q;
	logic [15:0] height_m_q;
	logic [31:0] height_scaled_q;

	assign hs_full = 48'(hm_s4) * 48'(cfg.vert_exag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else
			result_valid_q <= v_s4;
	end

	always_ff @(posedge clk) begin
		height_m_q      <= hm_s4;
		height_scaled_q <= hs_full[47:16];
	end

	assign result_valid  = result_valid_q;
	assign height_m      = height_m_q;
	assign height_scaled = height_scaled_q;

endmodule

// ===== hw/rtl/bilinear_grid_sampler.sv =====
// Bilinear height grid sampler with edge clamping.
// Command channel: an item is taken at a rising edge with start high and busy
// low. req_type selects a cell write (cell_col, cell_row, cell_height) or a
// point sample (query_x, query_y, signed Q16.16).
// Config port: cfg_we, cfg_idx, cfg_wdata write one register per edge, in the
// order x_origin, y_top, u_per_x, v_per_y, cols_in_use, rows_in_use,
// vert_exag. Write only while no sample is in flight.
// Result channel: result_valid pulses for one cycle with height_m (Q14.2)
// and height_scaled (Q18.14). Writes produce no result.
// An accepted sample passes the queue, the s1 to s4 registers and the output
// register before its result shows. Throughput is one item per cycle: the
// front queue drains every cycle into a pipeline of two 32x32 multipliers, a
// four-bank store split by row and column parity that delivers all four
// corners in one read, and three blend multipliers. busy therefore stays low
// in normal use. Reset clears the config registers and the pipeline; the
// height store is not cleared, so every cell must be written before it is
// sampled. The receiver cannot stall: results are never held back.
module bilinear_grid_sampler import bgs_pkg::*; #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [8:0]         cell_col,
	input  logic [8:0]         cell_row,
	input  logic [15:0]        cell_height,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output logic               result_valid,
	output logic [15:0]        height_m,
	output logic [31:0]        height_scaled
);

	bgs_cfg_t  cfg_q;
	logic      full;
	logic      push;
	bgs_item_t push_item;
	logic      pop;
	bgs_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_X_ORIGIN:    cfg_q.x_origin    <= cfg_wdata;
				CFG_Y_TOP:       cfg_q.y_top       <= cfg_wdata;
				CFG_U_PER_X:     cfg_q.u_per_x     <= cfg_wdata;
				CFG_V_PER_Y:     cfg_q.v_per_y     <= cfg_wdata;
				CFG_COLS_IN_USE: cfg_q.cols_in_use <= cfg_wdata[9:0];
				CFG_ROWS_IN_USE: cfg_q.rows_in_use <= cfg_wdata[9:0];
				CFG_VERT_EXAG:   cfg_q.vert_exag   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bgs_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.start       (start),
		.full        (full),
		.cfg         (cfg_q),
		.req_type    (req_type),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.cell_height (cell_height),
		.query_x     (query_x),
		.query_y     (query_y),
		.busy        (busy),
		.push        (push),
		.item        (push_item)
	);

	bgs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	bgs_back #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (pop),
		.in_item       (pop_item),
		.result_valid  (result_valid),
		.height_m      (height_m),
		.height_scaled (height_scaled)
	);

endmodule

// ===== bench/bgs_checker.sv =====
module bgs_checker import bgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        req_type,
	input  logic [8:0]  cell_col,
	input  logic [8:0]  cell_row,
	input  logic [15:0] cell_height,
	input  logic [31:0] query_x,
	input  logic [31:0] query_y,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        result_valid,
	input  logic [15:0] height_m,
	input  logic [31:0] height_scaled,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_COLS = 512;
	localparam int GRID_ROWS = 512;

	typedef struct {
		logic [15:0] hm;
		logic [31:0] hs;
	} height_res_t;

	typedef struct {
		int          i0;
		int          i1;
		logic [16:0] t;
	} axis_pick_t;

	bgs_cfg_t    shadow;
	logic [15:0] heights [0:GRID_COLS*GRID_ROWS-1];
	height_res_t height_q [$];

	function automatic axis_pick_t map_axis(logic signed [32:0] d, logic [31:0] scale, int n);
		logic [63:0] m;
		axis_pick_t  a;
		a.i0 = 0;
		a.i1 = 0;
		a.t  = '0;
		if (d >= 0) begin
			m = 64'(d[31:0]) * 64'(scale);
			if (64'(m[63:32]) >= 64'(n - 1)) begin
				a.i0 = n - 1;
				a.i1 = n - 1;
			end else begin
				a.i0 = int'(m[63:32]);
				a.i1 = a.i0 + 1;
				a.t  = {1'b0, m[31:16]};
			end
		end
		return a;
	endfunction

	function automatic height_res_t sample_height(logic [31:0] qx, logic [31:0] qy);
		int                 ncol, nrow;
		axis_pick_t         ax, ay;
		logic signed [32:0] dx, dy;
		logic [63:0]        h0, h1, bl, hs;
		height_res_t        r;
		ncol = shadow.cols_in_use > GRID_COLS ? GRID_COLS : int'(shadow.cols_in_use);
		nrow = shadow.rows_in_use > GRID_ROWS ? GRID_ROWS : int'(shadow.rows_in_use);
		r.hm = '0;
		r.hs = '0;
		if (ncol == 0 || nrow == 0 || shadow.u_per_x == 0 || shadow.v_per_y == 0)
			return r;
		dx = $signed({qx[31], qx}) - $signed({shadow.x_origin[31], shadow.x_origin});
		dy = $signed({shadow.y_top[31], shadow.y_top}) - $signed({qy[31], qy});
		ax = map_axis(dx, shadow.u_per_x, ncol);
		ay = map_axis(dy, shadow.v_per_y, nrow);
		h0 = 64'(heights[ay.i0*GRID_COLS + ax.i0]) * (64'd65536 - 64'(ax.t))
			+ 64'(heights[ay.i0*GRID_COLS + ax.i1]) * 64'(ax.t);
		h1 = 64'(heights[ay.i1*GRID_COLS + ax.i0]) * (64'd65536 - 64'(ax.t))
			+ 64'(heights[ay.i1*GRID_COLS + ax.i1]) * 64'(ax.t);
		bl = h0 * (64'd65536 - 64'(ay.t)) + h1 * 64'(ay.t);
		r.hm = bl[47:32];
		hs = (64'(r.hm) * 64'(shadow.vert_exag)) >> 16;
		r.hs = hs > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : hs[31:0];
		return r;
	endfunction

	assign pending = height_q.size();

	always @(posedge clk or negedge arst_n) begin
		height_res_t exp_r;
		if (!arst_n) begin
			shadow       <= '0;
			height_q.delete();
			errors       <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_X_ORIGIN:    shadow.x_origin    <= cfg_wdata;
					CFG_Y_TOP:       shadow.y_top       <= cfg_wdata;
					CFG_U_PER_X:     shadow.u_per_x     <= cfg_wdata;
					CFG_V_PER_Y:     shadow.v_per_y     <= cfg_wdata;
					CFG_COLS_IN_USE: shadow.cols_in_use <= cfg_wdata[9:0];
					CFG_ROWS_IN_USE: shadow.rows_in_use <= cfg_wdata[9:0];
					CFG_VERT_EXAG:   shadow.vert_exag   <= cfg_wdata;
					default: ;
				endcase
			end
			// compare before predicting so a same-edge sample cannot jump the queue
			if (result_valid) begin
				results_seen <= results_seen + 1;
				if (height_q.size() == 0) begin
					$display("%0t: unexpected result height_m=%h height_scaled=%h",
						$time, height_m, height_scaled);
					errors <= errors + 1;
				end else begin
					exp_r = height_q.pop_front();
					if (height_m !== exp_r.hm || height_scaled !== exp_r.hs) begin
						$display("%0t: mismatch height_m exp %h got %h, height_scaled exp %h got %h",
							$time, exp_r.hm, height_m, exp_r.hs, height_scaled);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE)
					heights[int'(cell_row)*GRID_COLS + int'(cell_col)] = cell_height;
				else
					height_q.insert(height_q.size(), sample_height(query_x, query_y));
			end
		end
	end

endmodule

// ===== bench/tb_bilinear_grid_sampler.sv =====
module tb_bilinear_grid_sampler;
	import bgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [8:0]  cell_col;
	logic [8:0]  cell_row;
	logic [15:0] cell_height;
	logic [31:0] query_x;
	logic [31:0] query_y;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	logic        result_valid;
	logic [15:0] height_m;
	logic [31:0] height_scaled;

	int errors, pending, results_seen;
	int idle_cycles = 0;
	int n_writes, n_samples, n_settings;
	bit no_gaps;

	// current setting, kept to aim queries at the grid
	logic [31:0] cur_xo, cur_yt, cur_u, cur_v;
	int          cur_cols, cur_rows;

	always #4 clk = ~clk;

	bilinear_grid_sampler i_dut (
		.clk, .arst_n, .start, .busy, .req_type, .cell_col, .cell_row, .cell_height,
		.query_x, .query_y, .cfg_we, .cfg_idx, .cfg_wdata, .result_valid, .height_m,
		.height_scaled
	);

	bgs_checker i_checker (
		.clk, .arst_n, .start, .busy, .req_type, .cell_col, .cell_row, .cell_height,
		.query_x, .query_y, .cfg_we, .cfg_idx, .cfg_wdata, .result_valid, .height_m,
		.height_scaled, .errors, .pending, .results_seen
	);

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, pending);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic gap();
		int r, n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!no_gaps) begin
			if (r >= 93)
				n = $urandom_range(8, 40);
			else if (r >= 70)
				n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(logic typ, logic [8:0] c, logic [8:0] r, logic [15:0] h,
			logic [31:0] qx, logic [31:0] qy);
		gap();
		start       <= 1'b1;
		req_type    <= typ;
		cell_col    <= c;
		cell_row    <= r;
		cell_height <= h;
		query_x     <= qx;
		query_y     <= qy;
		do @(posedge clk); while (busy);
		if (typ == REQ_WRITE)
			n_writes++;
		else
			n_samples++;
	endtask

	task automatic write_cell(int c, int r, logic [15:0] h);
		issue(REQ_WRITE, c[8:0], r[8:0], h, $urandom, $urandom);
	endtask

	task automatic sample(logic [31:0] qx, logic [31:0] qy);
		issue(REQ_SAMPLE, 9'($urandom), 9'($urandom), 16'($urandom), qx, qy);
	endtask

	// hold off until every outstanding sample has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic setup(logic [31:0] xo, logic [31:0] yt, logic [31:0] u, logic [31:0] v,
			logic [9:0] cols, logic [9:0] rows, logic [31:0] ve);
		drain();
		write_reg(CFG_X_ORIGIN, xo);
		write_reg(CFG_Y_TOP, yt);
		write_reg(CFG_U_PER_X, u);
		write_reg(CFG_V_PER_Y, v);
		write_reg(CFG_COLS_IN_USE, {22'h0, cols});
		write_reg(CFG_ROWS_IN_USE, {22'h0, rows});
		write_reg(CFG_VERT_EXAG, ve);
		cur_xo = xo;
		cur_yt = yt;
		cur_u  = u;
		cur_v  = v;
		cur_cols = cols > 512 ? 512 : int'(cols);
		cur_rows = rows > 512 ? 512 : int'(rows);
		n_settings++;
	endtask

	function automatic logic [15:0] rand_height();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// cover the whole grid in use so no sample reads an unwritten cell
	task automatic fill_grid();
		for (int r = 0; r < cur_rows; r++)
			for (int c = 0; c < cur_cols; c++)
				write_cell(c, r, rand_height());
	endtask

	// offset drawn from an eighth of (n + 1) cells before the origin to seven eighths past it
	function automatic logic [31:0] aim(logic [31:0] scale, int n);
		logic [63:0] span;
		logic [31:0] s32;
		if (scale == 0)
			return $urandom;
		span = ((64'(n) + 64'd1) << 32) / 64'(scale);
		s32 = span > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : span[31:0];
		return $urandom_range(0, s32) - (s32 >> 3);
	endfunction

	task automatic random_items(int count);
		logic [31:0] qx, qy;
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				write_cell($urandom_range(0, 511), $urandom_range(0, 511), rand_height());
			end else if (r < 40) begin
				sample($urandom, $urandom);
			end else begin
				qx = cur_xo + aim(cur_u, cur_cols);
				qy = cur_yt - aim(cur_v, cur_rows);
				sample(qx, qy);
			end
		end
	endtask

	initial begin
		logic [9:0] cols, rows;
		int pick;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= REQ_WRITE;
		cell_col    <= '0;
		cell_row    <= '0;
		cell_height <= '0;
		query_x     <= '0;
		query_y     <= '0;
		cfg_we      <= 1'b0;
		cfg_idx     <= CFG_X_ORIGIN;
		cfg_wdata   <= '0;
		no_gaps = 1'b0;
		n_writes = 0;
		n_samples = 0;
		n_settings = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// 2x2 grid, origin (1,3), one cell per unit, unit exaggeration
		setup(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 10'd2, 10'd2,
			32'h1000_0000);
		write_cell(0, 0, 16'h0000);
		write_cell(1, 0, 16'hFFFF);
		write_cell(0, 1, 16'h1234);
		write_cell(1, 1, 16'hFFFF);
		sample(32'h0001_0000, 32'h0003_0000);
		sample(32'h0002_0000, 32'h0002_0000);
		sample(32'h0001_8000, 32'h0002_8000);
		sample(32'h0001_0001, 32'h0002_FFFF);
		sample(32'h0000_0000, 32'h0004_0000);
		sample(32'h7FFF_FFFF, 32'h8000_0000);
		sample(32'h8000_0000, 32'h7FFF_FFFF);
		setup(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 10'd2, 10'd2,
			32'hFFFF_FFFF);
		sample(32'h0002_0000, 32'h0003_0000);
		sample(32'h0001_C000, 32'h0002_4000);
		// degenerate: each of the four zero conditions
		setup(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 10'd0, 10'd2,
			32'h1000_0000);
		sample(32'h0001_8000, 32'h0002_8000);
		setup(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 10'd2, 10'd0,
			32'h1000_0000);
		sample(32'h0001_8000, 32'h0002_8000);
		setup(32'h0001_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 10'd2, 10'd2,
			32'h1000_0000);
		sample(32'h0001_8000, 32'h0002_8000);
		setup(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0000_0000, 10'd2, 10'd2,
			32'h1000_0000);
		sample(32'h0001_8000, 32'h0002_8000);
		// oversized column count saturates to the store width; write the cells read
		setup(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1,
			32'h0000_0000);
		write_cell(0, 0, rand_height());
		write_cell(1, 0, rand_height());
		write_cell(511, 0, rand_height());
		sample(32'h8000_0000, 32'h7FFF_FFFF);
		sample(32'h8000_0001, 32'h7FFF_FFFF);
		sample(32'h7FFF_FFFF, 32'h8000_0000);
		sample(32'h8000_8000, 32'h7FFF_0000);
		// oversized row count saturates to the store height
		setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1, 10'd1023,
			32'h1000_0000);
		write_cell(0, 0, rand_height());
		write_cell(0, 1, rand_height());
		write_cell(0, 511, rand_height());
		sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		sample(32'h7FFF_FFFF, 32'h7FFF_FFFE);
		sample(32'h7FFF_FFFF, 32'h8000_0000);
		sample(32'h7FFF_FFFF, 32'h7FFF_8000);

		for (int ph = 0; ph < 10; ph++) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0: begin cols = 10'd1; rows = 10'($urandom_range(1, 20)); end
				1: begin cols = 10'($urandom_range(1, 20)); rows = 10'd1; end
				2: begin cols = 10'($urandom_range(25, 64)); rows = 10'd2; end
				3: begin cols = 10'd2; rows = 10'($urandom_range(25, 64)); end
				default: begin
					cols = 10'($urandom_range(2, 12));
					rows = 10'($urandom_range(2, 12));
				end
			endcase
			no_gaps = (ph % 3 == 2);
			setup($urandom, $urandom,
				ph == 0 ? 32'hFFFF_FFFF : ($urandom_range(0, 3) == 0 ? $urandom
					: $urandom_range(32'h0000_4000, 32'h0004_0000)),
				ph == 1 ? 32'h0000_0001 : ($urandom_range(0, 3) == 0 ? $urandom
					: $urandom_range(32'h0000_4000, 32'h0004_0000)),
				cols, rows,
				ph == 2 ? 32'hFFFF_FFFF : (ph == 3 ? 32'h0 : $urandom));
			fill_grid();
			random_items(25);
			if (ph == 4)
				drain();
			random_items(25);
		end
		no_gaps = 1'b0;
		drain();

		$display("covered %0d cell writes and %0d samples over %0d register settings",
			n_writes, n_samples, n_settings);
		$display("%0d results checked, %0d mismatches, %0d outstanding",
			results_seen, errors, pending);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bgs_pkg.sv
hw/rtl/bgs_front.sv
hw/rtl/bgs_queue.sv
hw/rtl/bgs_back.sv
hw/rtl/bilinear_grid_sampler.sv
bench/bgs_checker.sv
bench/tb_bilinear_grid_sampler.sv
